@@ hdl/bset_pkg.sv @@
// Shared types and constants for the bounded set block.
`default_nettype none

package bset_pkg;

  localparam int MAX_ELEMENTS = 16;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int COUNT_W      = 5;
  localparam int VALUE_W      = 32;
  localparam int OPCODE_W     = 2;

  localparam logic [COUNT_W-1:0] CAP_RESET = COUNT_W'(MAX_ELEMENTS);

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture the input beat
    logic exec;   // search, update the store, load the result register
  } bset_cmd_t;

endpackage

`default_nettype wire

@@ hdl/bset_in_if.sv @@
// Input channel: opcode and value with valid/ready.
`default_nettype none

interface bset_in_if;
  import bset_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

@@ hdl/bset_out_if.sv @@
// Result channel: membership, change flag and count with valid/ready.
`default_nettype none

interface bset_out_if;
  import bset_pkg::*;

  logic               valid;
  logic               ready;
  logic               was_present;
  logic               changed;
  logic [COUNT_W-1:0] element_count;

  modport source (output valid, output was_present, output changed, output element_count,
                  input ready);
  modport sink   (input valid, input was_present, input changed, input element_count,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/bset_ctrl.sv @@
// Controller: sequences accept, execute and the result register valid.
`default_nettype none

module bset_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  output bset_pkg::bset_cmd_t  cmd
);
  import bset_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.exec      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // result register must be free or draining this cycle
        if (!out_valid_r || out_ready) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  a_exec_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before it was taken");

  a_load_then_exec_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_EXEC))
    else $error("accepted beat did not move to execute");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> (out_valid_r && state_r == ST_IDLE))
    else $error("execute did not present a result");

endmodule

`default_nettype wire

@@ hdl/bset_dp.sv @@
// Datapath: row of element cells with parallel compare, shift-down delete, result register.
`default_nettype none

module bset_dp (
  input  wire                              clk,
  input  wire                              rst_n,
  input  bset_pkg::bset_cmd_t              cmd,
  input  wire  [bset_pkg::OPCODE_W-1:0]    in_opcode,
  input  wire  signed [bset_pkg::VALUE_W-1:0] in_value,
  input  wire                              cfg_we,
  input  wire  [bset_pkg::COUNT_W-1:0]     cfg_wdata,
  output logic                             res_was_present,
  output logic                             res_changed,
  output logic [bset_pkg::COUNT_W-1:0]     res_count
);
  import bset_pkg::*;

  logic [OPCODE_W-1:0]  op_r;
  logic [VALUE_W-1:0]   val_r;
  logic [COUNT_W-1:0]   cap_r;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [VALUE_W-1:0]   store_r   [MAX_ELEMENTS];
  logic [VALUE_W-1:0]   store_nxt [MAX_ELEMENTS];

  logic [MAX_ELEMENTS-1:0] hit;
  logic [MAX_ELEMENTS-1:0] shift_mask;
  logic [COUNT_W-1:0]      eff_cap;
  logic                    present;
  logic                    do_ins;
  logic                    do_del;
  logic                    was_present_r, changed_r;
  logic [COUNT_W-1:0]      res_count_r;

  // capacity above the store depth saturates
  assign eff_cap = (cap_r > CAP_RESET) ? CAP_RESET : cap_r;

  always_comb begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      hit[i] = (COUNT_W'(i) < count_r) && (store_r[i] == val_r);
    end
    // entries at and above the match move down on delete
    shift_mask[0] = hit[0];
    for (int i = 1; i < MAX_ELEMENTS; i++) begin
      shift_mask[i] = shift_mask[i-1] | hit[i];
    end
  end

  assign present = |hit;
  assign do_ins  = (op_r == OP_INSERT) && !present && (count_r < eff_cap);
  assign do_del  = (op_r == OP_DELETE) && present;

  always_comb begin
    store_nxt = store_r;
    count_nxt = count_r;
    if (cmd.exec && do_ins) begin
      store_nxt[count_r[IDX_W-1:0]] = val_r;
      count_nxt = count_r + 1'b1;
    end else if (cmd.exec && do_del) begin
      for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
        if (shift_mask[i]) begin
          store_nxt[i] = store_r[i+1];
        end
      end
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r   <= CAP_RESET;
    end else begin
      count_r <= count_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    store_r <= store_nxt;
    if (cmd.load) begin
      op_r  <= in_opcode;
      val_r <= in_value;
    end
    if (cmd.exec) begin
      was_present_r <= present;
      changed_r     <= do_ins | do_del;
      res_count_r   <= count_nxt;
    end
  end

  assign res_was_present = was_present_r;
  assign res_changed     = changed_r;
  assign res_count       = res_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_RESET)
    else $error("element count beyond store depth");

  a_insert_counts_up: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && do_ins) |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not advance the count");

  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> $onehot0(hit))
    else $error("duplicate element in the set");

endmodule

`default_nettype wire

@@ hdl/bounded_set_insert_delete_lookup.sv @@
// Top level of the bounded set: controller, datapath and channel hookup.
// A beat is captured in IDLE; EXEC commits it (compare row, shift and count
// update) and loads the result register once it is free or draining.
// No new beat is taken until that beat has executed: in_ready is high only when idle.
// Reset (rst_n low, synchronous): count to 0, capacity to 16, no result pending.
//   Element cells are not cleared; only entries below the count are looked at.
`default_nettype none

module bounded_set_insert_delete_lookup (
  input  wire                          clk,
  input  wire                          rst_n,
  bset_in_if.sink                      in_chan,
  bset_out_if.source                   out_chan,
  input  wire                          cfg_we,
  input  wire [bset_pkg::COUNT_W-1:0]  cfg_wdata
);
  import bset_pkg::*;

  bset_cmd_t cmd;

  // Controller: IDLE takes one beat, EXEC waits for the result register
  // to be free or draining, then commits the operation.
  bset_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  // Datapath: 16 element cells compared in parallel against the held value;
  // insert writes at the count, delete shifts the cells above the match down.
  // The result register holds the beat until the sink takes it.
  bset_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_opcode       (in_chan.opcode),
    .in_value        (in_chan.value),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .res_was_present (out_chan.was_present),
    .res_changed     (out_chan.changed),
    .res_count       (out_chan.element_count)
  );

endmodule

`default_nettype wire
